// ===== hw/rtl/rlfs_pkg.sv =====
// ----------------------------------------------------------------------------
// rlfs_pkg - shared types and helpers for the RGB LED fade step
// Level, step and result types, packing widths and the constant dividers
// used on the input side and in the fade datapath.
// ----------------------------------------------------------------------------
package rlfs_pkg;

  localparam int LevelW   = 12;
  localparam int ChanW    = 6;
  localparam int PwmW     = 10;
  localparam int UpStepW  = 7;   // 4095 / 50 = 81
  localparam int InDataW  = 96;  // 90 bits of fields, zero padded
  localparam int OutDataW = 88;  // 84 bits of fields, zero padded

  localparam logic [LevelW-1:0] DownStepReset = 12'd82;

  // Reciprocals for x / 50 and x / 5 over 12-bit x, both scaled by 2^16
  localparam logic [13:0] RecipDiv50 = 14'd1311;
  localparam logic [13:0] RecipDiv5  = 14'd13108;

  typedef enum logic {
    CMD_FADE_UP   = 1'b0,
    CMD_FADE_DOWN = 1'b1
  } cmd_t;

  typedef logic [LevelW-1:0]            level_t;
  typedef logic [2:0][LevelW-1:0]       level3_t;  // [0] red, [1] green, [2] blue
  typedef logic [2:0][UpStepW-1:0]      up_step3_t;
  typedef logic [2:0][PwmW-1:0]         pwm3_t;
  typedef logic [2:0][ChanW-1:0]        chan3_t;

  // One item as held in the input register
  typedef struct packed {
    cmd_t      cmd;
    level3_t   cur;
    level3_t   tgt;
    up_step3_t up_step;
  } fade_in_t;

  // One result as produced by the fade datapath
  typedef struct packed {
    level3_t lvl;
    pwm3_t   pwm;
    logic    done;
  } fade_out_t;

  // Floor of x / 50 by reciprocal multiply, exact for all 12-bit x
  function automatic logic [UpStepW-1:0] div_by_50(level_t x);
    logic [25:0] prod;
    begin
      prod = {14'd0, x} * {12'd0, RecipDiv50};
      return prod[16 +: UpStepW];
    end
  endfunction

  // Floor of x / 5 by reciprocal multiply, exact for all 12-bit x
  function automatic logic [PwmW-1:0] div_by_5(level_t x);
    logic [25:0] prod;
    begin
      prod = {14'd0, x} * {12'd0, RecipDiv5};
      return prod[16 +: PwmW];
    end
  endfunction

endpackage

// ===== hw/rtl/rlfs_fade_calc.sv =====
// ----------------------------------------------------------------------------
// rlfs_fade_calc - fade step datapath
// Combinational fade up / fade down of the three levels plus PWM drive
// values, placed between the input register and the result register.
// ----------------------------------------------------------------------------
module rlfs_fade_calc
  import rlfs_pkg::*;
(
  input  fade_in_t  item_i,
  input  level_t    down_step_i,
  output fade_out_t res_o
);

  // Lower channel idx by the step if it is nonzero and equals the current max
  function automatic level3_t lower_if_max(level3_t lv, logic [1:0] idx, level_t step);
    level_t  m;
    level3_t r;
    begin
      m = lv[0];
      if (lv[1] > m) m = lv[1];
      if (lv[2] > m) m = lv[2];
      r = lv;
      if (lv[idx] != '0 && lv[idx] == m) begin
        r[idx] = (lv[idx] > step) ? level_t'(lv[idx] - step) : '0;
      end
      return r;
    end
  endfunction

  logic [2:0][LevelW:0] up_sum;
  level3_t              up_lvl;
  level3_t              dn_lvl;
  level3_t              new_lvl;
  logic                 up_done;
  logic                 dn_done;

  // Fade up: add target/50 to levels below target, then clamp to target
  always_comb begin
    up_done = (item_i.cur == item_i.tgt);
    for (int i = 0; i < 3; i++) begin
      up_sum[i] = {1'b0, item_i.cur[i]} + {{(LevelW-UpStepW+1){1'b0}}, item_i.up_step[i]};
      if (item_i.cur[i] < item_i.tgt[i]) begin
        up_lvl[i] = (up_sum[i] > {1'b0, item_i.tgt[i]}) ? item_i.tgt[i]
                                                         : up_sum[i][LevelW-1:0];
      end else begin
        up_lvl[i] = item_i.tgt[i];
      end
    end
  end

  // Fade down: red, green, blue in turn, each against the levels so far
  always_comb begin
    dn_done = (item_i.cur == '0);
    dn_lvl  = lower_if_max(
                lower_if_max(
                  lower_if_max(item_i.cur, 2'd0, down_step_i),
                  2'd1, down_step_i),
                2'd2, down_step_i);
  end

  // Result select and PWM drive values
  always_comb begin
    if (item_i.cmd == CMD_FADE_DOWN) begin
      res_o.done = dn_done;
      new_lvl    = dn_done ? item_i.cur : dn_lvl;
    end else begin
      res_o.done = up_done;
      new_lvl    = up_done ? item_i.cur : up_lvl;
    end
    res_o.lvl = new_lvl;
    for (int i = 0; i < 3; i++) begin
      res_o.pwm[i] = div_by_5(new_lvl[i]);
    end
  end

endmodule

// ===== hw/rtl/rgb_led_fade_step.sv =====
// ----------------------------------------------------------------------------
// rgb_led_fade_step - one fade step for one RGB LED
// Stream in current levels, targets and channels; stream out new levels,
// PWM drive values, echoed channels and a done flag.
// ----------------------------------------------------------------------------
// Stages: input register, then result register behind the fade datapath.
// Throughput: one item per cycle; both registers advance together when the
//   result is taken or empty.
// Reset: rst_n low clears both valid flags and sets fade_down_step to 82.
module rgb_led_fade_step
  import rlfs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [LevelW-1:0]   cfg_data,     // fade_down_step

  input  logic                in_tvalid,
  output logic                in_tready,
  // current_red, current_green, current_blue, target_red, target_green,
  // target_blue, red_channel, green_channel, blue_channel, zero pad
  input  logic [InDataW-1:0]  in_tdata,
  input  logic                in_tuser,     // command

  output logic                out_tvalid,
  input  logic                out_tready,
  // new_red, new_green, new_blue, pwm_red, pwm_green, pwm_blue,
  // out_red_channel, out_green_channel, out_blue_channel, zero pad
  output logic [OutDataW-1:0] out_tdata,
  output logic                out_tuser     // done_res
);

  level_t    down_step_r;
  logic      s1_valid_r, s1_valid_nxt;
  fade_in_t  s1_item_r,  s1_item_nxt;
  chan3_t    s1_chan_r,  s1_chan_nxt;
  logic      out_valid_r, out_valid_nxt;
  fade_out_t out_res_r;
  chan3_t    out_chan_r;
  fade_out_t calc_res;
  logic      s1_adv;

  // Configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      down_step_r <= DownStepReset;
    end else if (cfg_valid && cfg_ready) begin
      down_step_r <= cfg_data;
    end
  end

  // Flow control: stage 1 moves on when the result register is free
  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;

  // Input register: unpack and precompute target/50
  always_comb begin
    s1_item_nxt.cmd = cmd_t'(in_tuser);
    for (int i = 0; i < 3; i++) begin
      s1_item_nxt.cur[i]     = in_tdata[i*LevelW +: LevelW];
      s1_item_nxt.tgt[i]     = in_tdata[(3+i)*LevelW +: LevelW];
      s1_item_nxt.up_step[i] = div_by_50(in_tdata[(3+i)*LevelW +: LevelW]);
      s1_chan_nxt[i]         = in_tdata[6*LevelW + i*ChanW +: ChanW];
    end
    s1_valid_nxt  = in_tready ? in_tvalid : s1_valid_r;
    out_valid_nxt = s1_adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r <= s1_item_nxt;
      s1_chan_r <= s1_chan_nxt;
    end
    if (s1_adv && s1_valid_r) begin
      out_res_r  <= calc_res;
      out_chan_r <= s1_chan_r;
    end
  end

  rlfs_fade_calc u_calc (
    .item_i      (s1_item_r),
    .down_step_i (down_step_r),
    .res_o       (calc_res)
  );

  // Result packing
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.done;
  assign out_tdata  = {4'd0,
                       out_chan_r[2], out_chan_r[1], out_chan_r[0],
                       out_res_r.pwm[2], out_res_r.pwm[1], out_res_r.pwm[0],
                       out_res_r.lvl[2], out_res_r.lvl[1], out_res_r.lvl[0]};

`ifndef SYNTHESIS
  // PWM value is the floor of level / 5 on every channel
  a_pwm_div5: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      ({4'd0, out_res_r.pwm[0]} * 14'd5 <= {2'd0, out_res_r.lvl[0]}) &&
      ({2'd0, out_res_r.lvl[0]} < {4'd0, out_res_r.pwm[0]} * 14'd5 + 14'd5) &&
      ({4'd0, out_res_r.pwm[1]} * 14'd5 <= {2'd0, out_res_r.lvl[1]}) &&
      ({2'd0, out_res_r.lvl[1]} < {4'd0, out_res_r.pwm[1]} * 14'd5 + 14'd5) &&
      ({4'd0, out_res_r.pwm[2]} * 14'd5 <= {2'd0, out_res_r.lvl[2]}) &&
      ({2'd0, out_res_r.lvl[2]} < {4'd0, out_res_r.pwm[2]} * 14'd5 + 14'd5))
    else $error("pwm value is not level / 5");

  // An empty input register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input stalled with empty stage 1");

  // A held stage 1 item is neither lost nor altered while the output stalls
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_item_r) && $stable(s1_chan_r)))
    else $error("stage 1 item changed during stall");

  // A taken result with nothing behind it leaves the output empty
  a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tready && !s1_valid_r) |=> !out_valid_r)
    else $error("result repeated after transfer");
`endif

endmodule

// ===== verif/rgb_led_fade_step_checker.sv =====
// ----------------------------------------------------------------------------
// rgb_led_fade_step_checker - result checker for the RGB LED fade step
// Watches the register, input and result channels. Works out the fade step
// for every input transfer from its own copy of the step register and
// compares each result transfer against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module rgb_led_fade_step_checker
  import rlfs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [LevelW-1:0]   cfg_data,

  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,
  input  logic                in_tuser,

  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OutDataW-1:0] out_tdata,
  input  logic                out_tuser,

  output int                  fault_count,
  output int                  pending_count
);

  // One LED result: new levels, drive values, echoed channels, done flag
  typedef struct packed {
    level3_t lvl;
    pwm3_t   pwm;
    chan3_t  chan;
    logic    done;
  } led_result_t;

  level_t      down_step = DownStepReset;
  led_result_t expected_q[$];
  int          faults = 0;
  int          pending = 0;
  int          result_no = 0;

  assign fault_count   = faults;
  assign pending_count = pending;

  // One fade step on the three levels
  function automatic led_result_t fade_step(cmd_t cmd, level3_t cur, level3_t tgt,
                                            chan3_t chan, level_t dstep);
    led_result_t res;
    int          lv[3];
    int          peak;
    begin
      res = '0;
      for (int i = 0; i < 3; i++) lv[i] = int'(cur[i]);
      if (cmd == CMD_FADE_UP) begin
        if (cur == tgt) begin
          res.done = 1'b1;
        end else begin
          // sum formed wide, then clamped to the target
          for (int i = 0; i < 3; i++) if (lv[i] < int'(tgt[i])) lv[i] += int'(tgt[i]) / 50;
          for (int i = 0; i < 3; i++) if (lv[i] > int'(tgt[i])) lv[i] = int'(tgt[i]);
        end
      end else begin
        if (cur == '0) begin
          res.done = 1'b1;
        end else begin
          // red, green, blue in turn, each against the levels updated so far
          for (int i = 0; i < 3; i++) begin
            peak = lv[0];
            if (lv[1] > peak) peak = lv[1];
            if (lv[2] > peak) peak = lv[2];
            if (lv[i] > 0 && lv[i] == peak)
              lv[i] = (lv[i] > int'(dstep)) ? lv[i] - int'(dstep) : 0;
          end
        end
      end
      for (int i = 0; i < 3; i++) begin
        res.lvl[i] = level_t'(lv[i]);
        res.pwm[i] = PwmW'(lv[i] / 5);
      end
      res.chan = chan;
      return res;
    end
  endfunction

  task automatic report_mismatch(string what);
    begin
      $display("rgb_led_fade_step_checker: result %0d: %s", result_no, what);
      faults++;
    end
  endtask

  task automatic compare_field(string field, int got, int want);
    begin
      if (got != want)
        report_mismatch($sformatf("%s is %0d, expected %0d", field, got, want));
    end
  endtask

  always @(posedge clk) begin
    led_result_t got;
    led_result_t want;
    string       colour [3];
    colour = '{"red", "green", "blue"};
    if (!rst_n) begin
      down_step = DownStepReset;
      expected_q.delete();
    end else begin
      // register write
      if (cfg_valid && cfg_ready) down_step = cfg_data;

      // input transfer: tdata = cur[0..2], tgt[0..2], chan[0..2] from bit 0 up
      if (in_tvalid && in_tready)
        expected_q.push_back(fade_step(cmd_t'(in_tuser), in_tdata[0 +: 36],
                                       in_tdata[36 +: 36], in_tdata[72 +: 18],
                                       down_step));

      // result transfer: tdata = lvl[0..2], pwm[0..2], chan[0..2] from bit 0 up
      if (out_tvalid && out_tready) begin
        got.lvl  = out_tdata[0 +: 36];
        got.pwm  = out_tdata[36 +: 30];
        got.chan = out_tdata[66 +: 18];
        got.done = out_tuser;
        if (expected_q.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = expected_q.pop_front();
          for (int i = 0; i < 3; i++) begin
            compare_field({"new_", colour[i]}, got.lvl[i], want.lvl[i]);
            compare_field({"pwm_", colour[i]}, got.pwm[i], want.pwm[i]);
            compare_field({"out_", colour[i], "_channel"}, got.chan[i], want.chan[i]);
          end
          compare_field("done_res", got.done, want.done);
        end
        result_no++;
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== verif/rgb_led_fade_step_test.sv =====
// ----------------------------------------------------------------------------
// rgb_led_fade_step_test - testbench top for the RGB LED fade step
// Drives directed and random fade items through the block under random
// idling on both streams, rewrites the fade down step between phases and
// leaves all checking to the checker beside the block.
// ----------------------------------------------------------------------------
module rgb_led_fade_step_test;
  import rlfs_pkg::*;

  localparam int PhaseItems = 550;
  localparam int CycleLimit = 200000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [LevelW-1:0]   cfg_data = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                in_tuser = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tuser;

  int fault_count;
  int pending_count;
  int tx_idle_pct = 8;
  int rx_idle_pct = 80;

  rgb_led_fade_step u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  rgb_led_fade_step_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .fault_count   (fault_count),
    .pending_count (pending_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("rgb_led_fade_step_test failed");
    $finish;
  end

  // Result side: random stalls, plus two long hold-offs to back the block up
  initial begin
    int rx_cycle;
    int hold_left;
    rx_cycle  = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle == 1500 || rx_cycle == 7000) hold_left = 300;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one item; valid stays high after the transfer unless a gap follows
  task automatic send_item(cmd_t cmd, level3_t cur, level3_t tgt, chan3_t chan);
    begin
      while ($urandom_range(99) < tx_idle_pct) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tuser  <= cmd;
      in_tdata  <= {6'd0, chan, tgt, cur};
      do @(posedge clk); while (!in_tready);
    end
  endtask

  // Stop offering and wait until every expected result has come out
  task automatic drain;
    begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while (pending_count != 0) @(posedge clk);
      repeat (4) @(posedge clk);
    end
  endtask

  task automatic write_down_step(level_t value);
    begin
      cfg_valid <= 1'b1;
      cfg_data  <= value;
      do @(posedge clk); while (!cfg_ready);
      cfg_valid <= 1'b0;
    end
  endtask

  // Levels biased toward zero, full scale and targets too small to step
  function automatic level_t draw_level();
    begin
      case ($urandom_range(7))
        0:       return '0;
        1:       return 12'd4095;
        2:       return level_t'($urandom_range(49));
        3:       return level_t'($urandom_range(4095, 3895));
        default: return level_t'($urandom_range(4095));
      endcase
    end
  endfunction

  task automatic send_random_item();
    cmd_t    cmd;
    level3_t cur;
    level3_t tgt;
    chan3_t  chan;
    int      pick;
    begin
      cmd = cmd_t'($urandom_range(1));
      for (int i = 0; i < 3; i++) begin
        cur[i]  = draw_level();
        tgt[i]  = draw_level();
        chan[i] = ChanW'($urandom_range(63));
      end
      pick = $urandom_range(7);
      if (cmd == CMD_FADE_UP) begin
        if (pick < 2) begin
          cur = tgt;
        end else if (pick < 4) begin
          cur = tgt;
          cur[$urandom_range(2)] = draw_level();
        end else if (pick == 4) begin
          // a little short of the target on every channel
          for (int i = 0; i < 3; i++)
            cur[i] = (tgt[i] > 12'd100) ? tgt[i] - level_t'($urandom_range(100)) : '0;
        end
      end else begin
        if (pick == 0) begin
          cur = '0;
        end else if (pick < 3) begin
          cur[$urandom_range(2)] = cur[$urandom_range(2)];
        end else if (pick == 3) begin
          cur[1] = cur[0];
          cur[2] = cur[0];
        end
      end
      send_item(cmd, cur, tgt, chan);
    end
  endtask

  // Stimulus; level and channel triples are written blue, green, red
  initial begin
    level_t phase_step [3];
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fade up at reset step: at target, off at zero target, full climb,
    // overshoot, small targets, above target, mixed
    send_item(CMD_FADE_UP,   {12'd300, 12'd200, 12'd100}, {12'd300, 12'd200, 12'd100},
              {6'd3, 6'd2, 6'd1});
    send_item(CMD_FADE_UP,   '0, '0, '0);
    send_item(CMD_FADE_UP,   '0, {3{12'd4095}}, {6'd63, 6'd0, 6'd63});
    send_item(CMD_FADE_UP,   {12'd0, 12'd4095, 12'd4090}, {3{12'd4095}}, {3{6'd63}});
    send_item(CMD_FADE_UP,   {12'd48, 12'd10, 12'd0}, {12'd49, 12'd30, 12'd49},
              {6'h15, 6'h2a, 6'h15});
    send_item(CMD_FADE_UP,   {12'd100, 12'd2000, 12'd4095}, {12'd50, 12'd1000, 12'd0},
              {6'h2a, 6'h15, 6'h2a});
    send_item(CMD_FADE_UP,   {12'd0, 12'd50, 12'd4000}, {12'd100, 12'd50, 12'd4095},
              {6'd7, 6'd8, 6'd9});
    send_item(CMD_FADE_UP,   '0, {3{12'd50}}, {6'd10, 6'd20, 6'd30});
    // Fade down at reset step: off, all tied, partial ties, small levels
    send_item(CMD_FADE_DOWN, '0, {3{12'd4095}}, {6'd1, 6'd1, 6'd1});
    send_item(CMD_FADE_DOWN, {3{12'd4095}}, '0, {6'd62, 6'd61, 6'd60});
    send_item(CMD_FADE_DOWN, {12'd50, 12'd100, 12'd100}, '0, {6'd5, 6'd4, 6'd3});
    send_item(CMD_FADE_DOWN, {12'd4095, 12'd4095, 12'd50}, '0, {6'd0, 6'd63, 6'd0});
    send_item(CMD_FADE_DOWN, {12'd30, 12'd20, 12'd10}, {3{12'd4095}}, {6'd11, 6'd12, 6'd13});
    send_item(CMD_FADE_DOWN, {12'd83, 12'd82, 12'd81}, '0, {6'd14, 6'd15, 6'd16});
    drain();

    // Smallest step
    write_down_step(12'd1);
    send_item(CMD_FADE_DOWN, {3{12'd4095}}, '0, {6'd17, 6'd18, 6'd19});
    send_item(CMD_FADE_DOWN, {3{12'd1}}, '0, {6'd20, 6'd21, 6'd22});
    send_item(CMD_FADE_DOWN, {12'd1, 12'd0, 12'd0}, '0, {6'd23, 6'd24, 6'd25});
    drain();

    // Largest step
    write_down_step(12'd4095);
    send_item(CMD_FADE_DOWN, {3{12'd4095}}, '0, {6'd26, 6'd27, 6'd28});
    send_item(CMD_FADE_DOWN, {12'd4094, 12'd0, 12'd4095}, '0, {6'd29, 6'd30, 6'd31});
    send_item(CMD_FADE_DOWN, {12'd2, 12'd4095, 12'd1}, '0, {6'd32, 6'd33, 6'd34});
    drain();

    // Step of zero leaves the levels where they are
    write_down_step(12'd0);
    send_item(CMD_FADE_DOWN, {12'd300, 12'd200, 12'd100}, '0, {6'd35, 6'd36, 6'd37});
    send_item(CMD_FADE_DOWN, {3{12'd5}}, '0, {6'd38, 6'd39, 6'd40});
    drain();

    // Random phases: receiver idle, then sender idle, then full rate
    phase_step[0] = DownStepReset;
    phase_step[1] = level_t'($urandom_range(200, 1));
    phase_step[2] = level_t'($urandom_range(4095, 1));
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 80 : 0;
      rx_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 8 : 0;
      write_down_step(phase_step[phase]);
      repeat (PhaseItems) send_random_item();
      drain();
    end

    if (fault_count == 0 && pending_count == 0) begin
      $display("rgb_led_fade_step_test passed");
    end else begin
      $display("rgb_led_fade_step_test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rlfs_pkg.sv
hw/rtl/rlfs_fade_calc.sv
hw/rtl/rgb_led_fade_step.sv
verif/rgb_led_fade_step_checker.sv
verif/rgb_led_fade_step_test.sv
